// File: rtl/desf_pkg.sv
// ----------------------------------------------------------------------------
// desf_pkg
// Shared types, constants and saturation helpers for the Holt linear
// smoothing forecaster.
// ----------------------------------------------------------------------------
package desf_pkg;

    localparam int GAIN_W      = 17;
    localparam int GAIN_BITS   = 16;
    localparam int SAMPLE_W    = 32;
    localparam int STATE_W     = 40;
    localparam int OPND_W      = STATE_W + 1;
    localparam int PROD_W      = GAIN_W + 1 + OPND_W;
    localparam int SHIFTED_W   = PROD_W - GAIN_BITS;
    localparam int BLEND_W     = SHIFTED_W + 1;
    localparam int STEP_W      = 7;
    localparam int FCAST_W     = STATE_W + STEP_W;
    localparam int CFG_IDX_W   = 1;
    localparam int DEF_MAX_HORIZON = 64;

    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1 << GAIN_BITS);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1 << (GAIN_BITS - 1));

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_FORECAST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TREND_GAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LVL_A,
        ST_LVL_B,
        ST_TRD_A,
        ST_TRD_B,
        ST_TRD_C,
        ST_FCAST
    } state_t;

    typedef enum logic [1:0] {
        MUL_AX,
        MUL_AV,
        MUL_BT,
        MUL_BD
    } mul_sel_t;

    typedef struct packed {
        logic              take_sample;
        logic              load_first;
        logic              load_second;
        mul_sel_t          mul_sel;
        logic              acc_load;
        logic              level_upd;
        logic              trend_upd;
        logic              fc_init;
        logic              emit;
        logic [STEP_W-1:0] emit_index;
        logic              emit_last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic [STATE_W-1:0] sat_state(input logic [BLEND_W-1:0] v);
        logic [STATE_W-1:0] r;
        if (v[BLEND_W-1:STATE_W-1] == '0 || v[BLEND_W-1:STATE_W-1] == '1)
            r = v[STATE_W-1:0];
        else if (v[BLEND_W-1])
            r = {1'b1, {(STATE_W-1){1'b0}}};
        else
            r = {1'b0, {(STATE_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] sat_out(input logic [FCAST_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        if (v[FCAST_W-1:SAMPLE_W-1] == '0 || v[FCAST_W-1:SAMPLE_W-1] == '1)
            r = v[SAMPLE_W-1:0];
        else if (v[FCAST_W-1])
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// File: rtl/desf_datapath.sv
// ----------------------------------------------------------------------------
// desf_datapath
// Gain registers, level and trend state, shared gain multiplier with
// product register, forecast accumulator and output register.
// ----------------------------------------------------------------------------
module desf_datapath
    import desf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data,
    input  logic [SAMPLE_W-1:0]    sample,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [SAMPLE_W-1:0]    prediction,
    output logic [STEP_W-1:0]      step_index,
    output logic                   last
);

    logic [GAIN_W-1:0]          level_gain_reg;
    logic [GAIN_W-1:0]          trend_gain_reg;
    logic [STATE_W-1:0]         level_reg;
    logic [STATE_W-1:0]         trend_reg;
    logic [STATE_W-1:0]         old_reg;
    logic [SAMPLE_W-1:0]        x_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [SHIFTED_W-1:0]       acc_reg;
    logic [FCAST_W-1:0]         fc_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        pred_reg;
    logic [STEP_W-1:0]          index_reg;
    logic                       last_reg;

    logic [GAIN_W-1:0]          gain_a;
    logic [GAIN_W-1:0]          gain_b;
    logic signed [GAIN_W:0]     g_op;
    logic signed [OPND_W-1:0]   u_op;
    logic signed [PROD_W-1:0]   prod_next;
    logic [SHIFTED_W-1:0]       prod_sh;
    logic [BLEND_W-1:0]         blend_sum;
    logic [OPND_W-1:0]          lt_sum;
    logic [OPND_W-1:0]          lvl_diff;
    logic [OPND_W-1:0]          first_diff;
    logic [FCAST_W-1:0]         fc_next;

    assign gain_a = (level_gain_reg > GAIN_ONE) ? GAIN_ONE : level_gain_reg;
    assign gain_b = (trend_gain_reg > GAIN_ONE) ? GAIN_ONE : trend_gain_reg;

    assign lt_sum   = {level_reg[STATE_W-1], level_reg} + {trend_reg[STATE_W-1], trend_reg};
    assign lvl_diff = {level_reg[STATE_W-1], level_reg} - {old_reg[STATE_W-1], old_reg};
    assign first_diff = {{(OPND_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample}
                      - {level_reg[STATE_W-1], level_reg};

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_AX:
            begin
                g_op = {1'b0, gain_a};
                u_op = {{(OPND_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
            end
            MUL_AV:
            begin
                g_op = {1'b0, GAIN_ONE - gain_a};
                u_op = lt_sum;
            end
            MUL_BT:
            begin
                g_op = {1'b0, GAIN_ONE - gain_b};
                u_op = {trend_reg[STATE_W-1], trend_reg};
            end
            MUL_BD:
            begin
                g_op = {1'b0, gain_b};
                u_op = lvl_diff;
            end
            default:
            begin
                g_op = '0;
                u_op = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(g_op) * PROD_W'(u_op);
    // floor shift by the gain's fraction bits
    assign prod_sh   = prod_reg[PROD_W-1:GAIN_BITS];
    assign blend_sum = {acc_reg[SHIFTED_W-1], acc_reg} + {prod_sh[SHIFTED_W-1], prod_sh};
    assign fc_next   = fc_reg + {{(FCAST_W-STATE_W){trend_reg[STATE_W-1]}}, trend_reg};

    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_gain_reg <= GAIN_RESET;
            trend_gain_reg <= GAIN_RESET;
            level_reg      <= '0;
            trend_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LEVEL_GAIN: level_gain_reg <= cfg_data;
                    REG_TREND_GAIN: trend_gain_reg <= cfg_data;
                    default:        level_gain_reg <= level_gain_reg;
                endcase
            end
            if (cmd.load_first)
            begin
                level_reg <= {{(STATE_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
                trend_reg <= '0;
            end
            else if (cmd.load_second)
            begin
                level_reg <= {{(STATE_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
                trend_reg <= sat_state({{(BLEND_W-OPND_W){first_diff[OPND_W-1]}},
                                        first_diff});
            end
            else if (cmd.level_upd)
                level_reg <= sat_state(blend_sum);
            else if (cmd.trend_upd)
                trend_reg <= sat_state(blend_sum);

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.take_sample)
            x_reg <= sample;
        if (cmd.acc_load)
            acc_reg <= prod_sh;
        if (cmd.level_upd)
            old_reg <= level_reg;
        if (cmd.fc_init)
            fc_reg <= {{(FCAST_W-STATE_W){level_reg[STATE_W-1]}}, level_reg};
        else if (cmd.emit)
            fc_reg <= fc_next;
        if (cmd.emit)
        begin
            pred_reg  <= sat_out(fc_next);
            index_reg <= cmd.emit_index;
            last_reg  <= cmd.emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign prediction = pred_reg;
    assign step_index = index_reg;
    assign last       = last_reg;

endmodule

// File: rtl/desf_controller.sv
// ----------------------------------------------------------------------------
// desf_controller
// Sequencer: series phase tracking, smoothing multiply schedule and
// forecast step counting.
// ----------------------------------------------------------------------------
module desf_controller
    import desf_pkg::*;
#(
    parameter int MAX_HORIZON = DEF_MAX_HORIZON
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic              new_series,
    input  logic [STEP_W-1:0] steps,
    input  status_t           status,
    output cmd_t              cmd
);

    localparam logic [STEP_W-1:0] MAX_H = STEP_W'(MAX_HORIZON);

    state_t            state_reg, state_next;
    logic [1:0]        seen_reg, seen_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] total_reg, total_next;
    logic [STEP_W-1:0] horizon;
    logic [STEP_W-1:0] step_inc;

    assign horizon  = (steps > MAX_H) ? MAX_H : steps;
    assign step_inc = step_reg + STEP_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seen_reg  <= '0;
            step_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            step_reg  <= step_next;
            total_reg <= total_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        step_next  = step_reg;
        total_next = total_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        cmd.mul_sel    = MUL_AX;
        cmd.emit_index = step_inc;
        cmd.emit_last  = (step_inc == total_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (opcode == OP_SAMPLE)
                    begin
                        if (new_series || seen_reg == 2'd0)
                        begin
                            cmd.load_first = 1'b1;
                            seen_next      = 2'd1;
                        end
                        else if (seen_reg == 2'd1)
                        begin
                            cmd.load_second = 1'b1;
                            seen_next       = 2'd2;
                        end
                        else
                        begin
                            cmd.take_sample = 1'b1;
                            state_next      = ST_LVL_A;
                        end
                    end
                    else
                    begin
                        step_next  = '0;
                        total_next = horizon;
                        if (horizon != '0)
                        begin
                            cmd.fc_init = 1'b1;
                            state_next  = ST_FCAST;
                        end
                    end
                end
            end
            ST_LVL_A:
            begin
                cmd.mul_sel = MUL_AX;
                state_next  = ST_LVL_B;
            end
            ST_LVL_B:
            begin
                cmd.mul_sel  = MUL_AV;
                cmd.acc_load = 1'b1;
                state_next   = ST_TRD_A;
            end
            ST_TRD_A:
            begin
                cmd.mul_sel   = MUL_BT;
                cmd.level_upd = 1'b1;
                state_next    = ST_TRD_B;
            end
            ST_TRD_B:
            begin
                cmd.mul_sel  = MUL_BD;
                cmd.acc_load = 1'b1;
                state_next   = ST_TRD_C;
            end
            ST_TRD_C:
            begin
                cmd.trend_upd = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_FCAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit  = 1'b1;
                    step_next = step_inc;
                    if (step_inc == total_reg)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/double_exponential_smoothing_forecast_top.sv
// ----------------------------------------------------------------------------
// double_exponential_smoothing_forecast_top
// Holt linear smoothing forecaster: sample items update level and trend,
// forecast items emit level + i*trend for i = 1..steps, capped at MAX_HORIZON.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in      | sink      | in_valid/in_stall   | opcode, sample, new_series, steps
//   out     | source    | out_valid/out_stall | prediction, step_index, last
//   cfg     | sink      | cfg_we              | cfg_index, cfg_data
//
// First and second samples of a series are loaded directly. Later samples
// run the level and trend states, set by four dependent products through
// one shared multiplier. Forecast: one result per cycle while out is free.
// Reset clears level, trend, series phase and sets both gains to one half.
// Output is registered; the next item is taken while a result waits.
// ----------------------------------------------------------------------------
module double_exponential_smoothing_forecast_top
    import desf_pkg::*;
#(
    parameter int MAX_HORIZON = DEF_MAX_HORIZON
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                   new_series,
    input  logic [STEP_W-1:0]      steps,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [SAMPLE_W-1:0] prediction,
    output logic [STEP_W-1:0]      step_index,
    output logic                   last
);

    cmd_t    cmd;
    status_t status;

    desf_controller #(
        .MAX_HORIZON (MAX_HORIZON)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .new_series (new_series),
        .steps      (steps),
        .status     (status),
        .cmd        (cmd)
    );

    desf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .cmd        (cmd),
        .status     (status),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .prediction (prediction),
        .step_index (step_index),
        .last       (last)
    );

endmodule

// File: rtl/desf_checker.sv
// ----------------------------------------------------------------------------
// desf_checker
// Port-level checks on the forecaster, bound to the top level.
// ----------------------------------------------------------------------------
module desf_checker
    import desf_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   opcode,
    input logic [STEP_W-1:0]      steps,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [SAMPLE_W-1:0]    prediction,
    input logic [STEP_W-1:0]      step_index,
    input logic                   last
);

    // stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(prediction)
            && $stable(step_index) && $stable(last))
        else $error("stalled output item changed");

    // more results pending: input side stays closed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input opened during forecast run");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_FORECAST && steps != '0 |=> in_stall)
        else $error("forecast item did not start a run");

    // sample items produce nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_SAMPLE |=> !$rose(out_valid))
        else $error("sample item produced a result");

endmodule

bind double_exponential_smoothing_forecast_top desf_checker u_checker (.*);
